// ----- design/tskrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tskrb_pkg
// shared types, codes and saturating fixed point helpers for the rate/bias
// kalman filter
// ----------------------------------------------------------------------------
package tskrb_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
  localparam int QCNT_BITS = $clog2(QUO_BITS + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  // config register indexes
  localparam logic [2:0] REG_QX = 3'd0;
  localparam logic [2:0] REG_QB = 3'd1;
  localparam logic [2:0] REG_RX = 3'd2;
  localparam logic [2:0] REG_C  = 3'd3;

  typedef struct packed {
    logic [15:0]        time_step;
    logic signed [31:0] meas_pos;
    logic signed [31:0] meas_rate;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] est_pos;
    logic signed [31:0] est_rate;
    logic signed [31:0] bias_out;
  } out_word_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [31:0] data;
  } cfg_word_t;

  // operation codes of the shared unit
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    word_t a;
    word_t b;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    word_t y;
  } unit_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DONE
  } state_t;

  function automatic word_t sadd(word_t a, word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return s[WORD_BITS-1:0];
  endfunction

endpackage

// ----- design/tskrb_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tskrb_unit
// shared fixed point multiply / divide unit: one signed product or one
// restoring divide, a quotient bit per cycle
// ----------------------------------------------------------------------------
module tskrb_unit (
  input  logic               clk,
  input  logic               rst,
  input  tskrb_pkg::unit_req_t req,
  output tskrb_pkg::unit_rsp_t rsp
);
  import tskrb_pkg::*;

  localparam int MAG_BITS = WORD_BITS;

  logic                     busy;
  logic                     mul_stage;
  logic                     neg;
  logic [QCNT_BITS-1:0]     cnt;
  logic [MAG_BITS-1:0]      ma;
  logic [MAG_BITS-1:0]      mb;
  logic [PROD_BITS-1:0]     prod;
  logic [QUO_BITS-1:0]      num;
  logic [QUO_BITS-1:0]      quo;
  logic [MAG_BITS:0]        rem;
  logic                     is_div;
  logic                     done;
  word_t                    y;

  logic [MAG_BITS-1:0]      mag_a;
  logic [MAG_BITS-1:0]      mag_b;
  logic [MAG_BITS:0]        rem_sh;
  logic [PROD_BITS-1:0]     prod_sh;

  always_comb begin
    mag_a  = req.a[WORD_BITS-1] ? MAG_BITS'(-req.a) : MAG_BITS'(req.a);
    mag_b  = req.b[WORD_BITS-1] ? MAG_BITS'(-req.b) : MAG_BITS'(req.b);
    rem_sh = {rem[MAG_BITS-1:0], num[QUO_BITS-1]};
    prod_sh = prod >> FRAC_BITS;
  end

  // saturate a magnitude to the signed word range
  function automatic word_t fin(logic n, logic [QUO_BITS+WORD_BITS-1:0] m);
    logic [QUO_BITS+WORD_BITS-1:0] lim;
    logic [QUO_BITS+WORD_BITS-1:0] v;
    lim = (QUO_BITS+WORD_BITS)'(WORD_MAX) + (QUO_BITS+WORD_BITS)'(n);
    v = (m > lim) ? lim : m;
    return n ? word_t'(-v) : word_t'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mul_stage <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      is_div <= (req.op == OP_DIV);
      ma <= mag_a;
      mb <= mag_b;
      num <= {mag_a, {FRAC_BITS{1'b0}}};
      rem <= '0;
      quo <= '0;
      cnt <= QCNT_BITS'(QUO_BITS);
      if (req.op == OP_DIV) begin
        neg <= req.a[WORD_BITS-1];
        mul_stage <= 1'b0;
        if (req.b[WORD_BITS-1] || req.b == '0) begin
          // divisor not positive: quotient is zero
          y <= '0;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          done <= 1'b0;
        end
      end else begin
        neg <= req.a[WORD_BITS-1] ^ req.b[WORD_BITS-1];
        mul_stage <= 1'b1;
        busy <= 1'b0;
        done <= 1'b0;
      end
    end else if (mul_stage) begin
      prod <= PROD_BITS'(ma) * PROD_BITS'(mb);
      mul_stage <= 1'b0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && !is_div) begin
      y <= fin(neg, (QUO_BITS+WORD_BITS)'(prod_sh));
      busy <= 1'b0;
      done <= 1'b1;
    end else if (busy) begin
      num <= num << 1;
      if (rem_sh >= {1'b0, mb}) begin
        rem <= rem_sh - {1'b0, mb};
        quo <= {quo[QUO_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QUO_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      busy <= (cnt != QCNT_BITS'(1));
      done <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end

  // divide result is formed the cycle after the last quotient bit
  logic div_fin;
  always_ff @(posedge clk) begin
    if (rst) div_fin <= 1'b0;
    else div_fin <= busy && is_div && cnt == QCNT_BITS'(1);
  end

  assign rsp.done = done || div_fin;
  assign rsp.y = div_fin ? fin(neg, (QUO_BITS+WORD_BITS)'(quo)) : y;

endmodule

// ----- design/two_state_kalman_rate_bias_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_state_kalman_rate_bias_top
// two-state kalman filter fusing position and rate, estimating rate bias
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_ready / in_data) takes one word: time step,
//   measured position, measured rate. out channel (out_valid / out_ready /
//   out_data) returns one word per input: position, corrected rate, bias.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the noise and
//   observation registers; index beyond the list is ignored. write only idle.
// sequence
//   each word runs 16 operations through one shared multiply/divide unit:
//   14 multiplies and 2 divides, issued one at a time and waited on in
//   turn, then the result is loaded into the output register. with a
//   non-positive innovation variance a divide returns zero without running
//   the divider loop. in_ready is low while a word is in work, so the next
//   word is taken only once the result of the last one is loaded.
// reset
//   synchronous rst clears state, covariance and restores register defaults.
// stall
//   a result waits in the output register while the next word is worked;
//   that word holds before loading its result until the register is free.
// ----------------------------------------------------------------------------
module two_state_kalman_rate_bias_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tskrb_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tskrb_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tskrb_pkg::cfg_word_t cfg_data
);
  import tskrb_pkg::*;

  // registers
  word_t qx, qb, rx, cg;
  // filter state
  word_t xp, xb, p0, p1, p2, p3;
  // per word temporaries
  word_t dt, zp, zr, err, pct0, pct1, e, k0, k1, t1, d0, d1;

  state_t state, state_next;
  logic [4:0] op_idx;
  unit_req_t req;
  unit_rsp_t rsp;

  localparam logic [4:0] OP_LAST = 5'd15;

  logic out_free;

  tskrb_unit u_unit (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  // output register can take a new result
  assign out_free = !out_valid || out_ready;

  // operand selection per step
  always_comb begin
    req.start = (state == S_ISSUE);
    req.op = OP_MUL;
    req.a = '0;
    req.b = dt;
    case (op_idx)
      5'd0:  req.a = ssub(zr, xb);
      5'd1:  req.a = d0;
      5'd2:  req.a = d1;
      5'd3:  req.a = qb;
      5'd4:  begin req.a = cg; req.b = p0; end
      5'd5:  begin req.a = cg; req.b = p2; end
      5'd6:  begin req.a = cg; req.b = pct0; end
      5'd7:  begin req.op = OP_DIV; req.a = pct0; req.b = e; end
      5'd8:  begin req.op = OP_DIV; req.a = pct1; req.b = e; end
      5'd9:  begin req.a = cg; req.b = p1; end
      5'd10: begin req.a = k0; req.b = pct0; end
      5'd11: begin req.a = k0; req.b = t1; end
      5'd12: begin req.a = k1; req.b = pct0; end
      5'd13: begin req.a = k1; req.b = t1; end
      5'd14: begin req.a = k0; req.b = err; end
      5'd15: begin req.a = k1; req.b = err; end
      default: begin req.a = '0; req.b = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && in_ready) state_next = S_ISSUE;
      S_ISSUE: state_next = S_WAIT;
      S_WAIT:  if (rsp.done) state_next = (op_idx == OP_LAST) ? S_DONE : S_ISSUE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qx <= word_t'(66); qb <= word_t'(197); rx <= word_t'(32768); cg <= word_t'(65536);
      xp <= '0; xb <= '0; p0 <= '0; p1 <= '0; p2 <= '0; p3 <= '0;
      out_valid <= 1'b0;
      op_idx <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_data.idx)
          REG_QX: qx <= word_t'({1'b0, cfg_data.data[30:0]});
          REG_QB: qb <= word_t'({1'b0, cfg_data.data[30:0]});
          REG_RX: rx <= word_t'({1'b0, cfg_data.data[30:0]});
          REG_C:  cg <= word_t'(cfg_data.data);
          default: ;
        endcase
      end
      if (state == S_IDLE && in_valid && in_ready) begin
        dt <= word_t'({16'd0, in_data.time_step});
        zp <= in_data.meas_pos;
        zr <= in_data.meas_rate;
        op_idx <= '0;
        // predict covariance deltas from current covariance
        d0 <= ssub(ssub(qx, p1), p2);
        d1 <= ssub('0, p3);
      end
      if (state == S_WAIT && rsp.done) begin
        op_idx <= op_idx + 1'b1;
        case (op_idx)
          5'd0: begin xp <= sadd(xp, rsp.y); err <= ssub(zp, sadd(xp, rsp.y)); end
          5'd1: p0 <= sadd(p0, rsp.y);
          5'd2: begin p1 <= sadd(p1, rsp.y); p2 <= sadd(p2, rsp.y); end
          5'd3: p3 <= sadd(p3, rsp.y);
          5'd4: pct0 <= rsp.y;
          5'd5: pct1 <= rsp.y;
          5'd6: e <= sadd(rx, rsp.y);
          5'd7: k0 <= rsp.y;
          5'd8: k1 <= rsp.y;
          5'd9: t1 <= rsp.y;
          5'd10: p0 <= ssub(p0, rsp.y);
          5'd11: p1 <= ssub(p1, rsp.y);
          5'd12: p2 <= ssub(p2, rsp.y);
          5'd13: p3 <= ssub(p3, rsp.y);
          5'd14: xp <= sadd(xp, rsp.y);
          5'd15: xb <= sadd(xb, rsp.y);
          default: ;
        endcase
      end
      // load the result once the output register is free
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_data.est_pos <= xp;
        out_data.est_rate <= ssub(zr, xb);
        out_data.bias_out <= xb;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result only appears at the end of a sequence
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("stray result");
  // unit started only from the issue state
  a_start: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == S_ISSUE) else $error("bad start");
  // no input taken while working
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
  // step index never passes one beyond the last op
  a_idx: assert property (@(posedge clk) disable iff (rst)
    op_idx <= OP_LAST + 5'd1) else $error("index overrun");

endmodule
